// ===== rtl/fcr_pkg.sv =====
// Shared types, constants and the CRC-8 step for the frame receiver.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package fcr_pkg;

	localparam int FRAME_LENGTH  = 20;
	localparam int STORE_DEPTH   = FRAME_LENGTH - 1;  // bytes 0..18; byte 19 is the CRC
	localparam int POS_W         = 5;
	localparam int ADC_MAX       = 8;
	localparam int DAC_MAX       = 2;
	localparam int SAMPLE_W      = 12;
	localparam int ADC_START     = 2;
	localparam int DAC_START     = 16;
	localparam int DIGITAL_INDEX = 14;
	localparam int HEADER_INDEX  = 0;
	localparam int M_TDATA_W     = (ADC_MAX + DAC_MAX) * SAMPLE_W + 8;

	localparam logic [POS_W-1:0] CRC_POS = POS_W'(FRAME_LENGTH - 1);

	localparam logic [7:0] HEADER_RESET = 8'h1B;
	localparam logic [7:0] POLY_RESET   = 8'h07;

	// Configuration register indexes
	localparam logic [0:0] REG_HEADER = 1'b0;
	localparam logic [0:0] REG_POLY   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_HDR_ERR = 2'd2
	} fcr_status_t;

	typedef logic [STORE_DEPTH-1:0][7:0] fcr_frame_t;

	// Event from the collector to the unpacker for the item being retired
	typedef struct packed {
		logic last;    // last byte of a frame
		logic crc_ok;  // running CRC equals the last byte
	} fcr_event_t;

	// One byte of an MSB-first CRC-8, no reflection, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crc8_frame_receiver_unpacker.sv =====
// CRC-8 frame receiver and unpacker, top level.
// Depends on fcr_pkg, fcr_in_stage, fcr_collect and fcr_unpack.
//
// Input stream (s_axis): one item per received byte; tuser = 1 marks an idle
// timeout that drops the partial frame (tdata is ignored then). Bytes form
// fixed 20-byte frames: byte 0 is the header, bytes 2..13 carry eight 12-bit
// ADC samples, byte 14 the digital inputs, bytes 16..18 two DAC samples and
// byte 19 the CRC-8 over bytes 0..18.
// Output stream (m_axis): one item per completed frame, carrying the status
// in tuser and the held values as they stand after that frame in tdata. A
// frame with a bad CRC or header leaves the held values as they were.
// Config channel: cfg_index 0 writes the expected header, 1 the polynomial;
// cfg_ready is always high. Write only while no frame is in flight.
// Throughput is one item per cycle while m_axis does not stall: the CRC byte
// step is combinational logic between the input register and the collector
// state. A result is registered onto m_axis as the collector retires its last
// byte from the input register. When m_axis stalls, the result holds and the
// input register fills, then s_axis_tready drops.
// Reset clears position, CRC, held values (to zero) and the registers to
// header 0x1B and polynomial 0x07; it takes effect at once.
`default_nettype none

module crc8_frame_receiver_unpacker #(
	parameter int ADC_CHANNELS = 8,
	parameter int DAC_CHANNELS = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	input  wire logic [0:0] s_axis_tuser,   // [0] op
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	// [11:0] adc_ch0 .. [95:84] adc_ch7, [107:96] dac_ch0, [119:108] dac_ch1,
	// [127:120] digital_inputs
	output logic [fcr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]      m_axis_tuser,   // [1:0] status
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import fcr_pkg::*;

	logic [7:0] header_val_q;
	logic [7:0] poly_q;
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;
	fcr_event_t evt;
	fcr_frame_t frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_val_q <= HEADER_RESET;
			poly_q       <= POLY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER: header_val_q <= cfg_data;
				REG_POLY:   poly_q       <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign advance = valid_s1 && out_free;

	fcr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser[0]),
		.in_byte  (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.byte_s1  (byte_s1)
	);

	fcr_collect u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.op_s1    (op_s1),
		.byte_s1  (byte_s1),
		.crc_poly (poly_q),
		.evt      (evt),
		.frame    (frame)
	);

	fcr_unpack #(
		.ADC_CHANNELS (ADC_CHANNELS),
		.DAC_CHANNELS (DAC_CHANNELS)
	) u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.frame      (frame),
		.header     (header_val_q),
		.out_free   (out_free),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_data   (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/fcr_in_stage.sv =====
// Input register stage of the frame receiver: holds one accepted item.
// Depends on fcr_pkg.
`default_nettype none

module fcr_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       in_op,
	input  wire logic [7:0] in_byte,
	input  wire logic       advance,   // downstream takes the held item this cycle
	output logic            valid_s1,
	output logic            op_s1,
	output logic [7:0]      byte_s1
);
	import fcr_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= in_op;
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fcr_collect.sv =====
// Frame collector: byte position, running CRC-8 and the byte store of the open frame.
// Depends on fcr_pkg.
`default_nettype none

module fcr_collect (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic       op_s1,
	input  wire logic [7:0] byte_s1,
	input  wire logic [7:0] crc_poly,
	output fcr_pkg::fcr_event_t evt,
	output fcr_pkg::fcr_frame_t frame
);
	import fcr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic [7:0]       store_q [STORE_DEPTH];
	logic             at_crc;

	assign at_crc     = (pos_q == CRC_POS);
	assign evt.last   = advance && !op_s1 && at_crc;
	assign evt.crc_ok = (crc_q == byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '0;
		end else if (advance) begin
			if (op_s1 || at_crc) begin
				// timeout drops the partial frame; the CRC byte closes it
				pos_q <= '0;
				crc_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				crc_q <= crc8_update(crc_q, byte_s1, crc_poly);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (advance && !op_s1 && (pos_q == POS_W'(i))) begin
				store_q[i] <= byte_s1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			frame[i] = store_q[i];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fcr_unpack.sv =====
// Frame check and unpacker: status, held ADC/DAC/digital values and the result register.
// Depends on fcr_pkg.
`default_nettype none

module fcr_unpack #(
	parameter int ADC_CHANNELS = 8,
	parameter int DAC_CHANNELS = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire fcr_pkg::fcr_event_t evt,
	input  wire fcr_pkg::fcr_frame_t frame,
	input  wire logic [7:0] header,
	output logic            out_free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      out_status,
	output logic [fcr_pkg::M_TDATA_W-1:0] out_data
);
	import fcr_pkg::*;

	logic        valid_q;
	fcr_status_t status_q;
	fcr_status_t status_c;
	logic        load;
	logic [7:0]  digital_q;
	logic [SAMPLE_W-1:0] adc [ADC_MAX];
	logic [SAMPLE_W-1:0] dac [DAC_MAX];

	assign out_free = !valid_q || out_ready;

	always_comb begin
		if (!evt.crc_ok) begin
			status_c = ST_CRC_ERR;
		end else if (frame[HEADER_INDEX] != header) begin
			status_c = ST_HDR_ERR;
		end else begin
			status_c = ST_OK;
		end
	end

	assign load = evt.last && (status_c == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (evt.last) begin
				valid_q  <= 1'b1;
				status_q <= status_c;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digital_q <= '0;
		end else if (load) begin
			digital_q <= frame[DIGITAL_INDEX];
		end
	end

	// Two 12-bit samples per three bytes: {a, hi(a+1)} and {lo(a+1), a+2}
	for (genvar ch = 0; ch < ADC_MAX; ch++) begin : g_adc
		localparam int A = ADC_START + 3 * (ch / 2);
		if (ch < ADC_CHANNELS) begin : g_held
			logic [SAMPLE_W-1:0] held_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					held_q <= '0;
				end else if (load) begin
					if (ch % 2 == 0) begin
						held_q <= {frame[A], frame[A+1][7:4]};
					end else begin
						held_q <= {frame[A+1][3:0], frame[A+2]};
					end
				end
			end
			assign adc[ch] = held_q;
		end else begin : g_unused
			assign adc[ch] = '0;
		end
	end

	for (genvar ch = 0; ch < DAC_MAX; ch++) begin : g_dac
		localparam int A = DAC_START + 3 * (ch / 2);
		if (ch < DAC_CHANNELS) begin : g_held
			logic [SAMPLE_W-1:0] held_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					held_q <= '0;
				end else if (load) begin
					if (ch % 2 == 0) begin
						held_q <= {frame[A], frame[A+1][7:4]};
					end else begin
						held_q <= {frame[A+1][3:0], frame[A+2]};
					end
				end
			end
			assign dac[ch] = held_q;
		end else begin : g_unused
			assign dac[ch] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < ADC_MAX; i++) begin
			out_data[i*SAMPLE_W +: SAMPLE_W] = adc[i];
		end
		for (int i = 0; i < DAC_MAX; i++) begin
			out_data[(ADC_MAX+i)*SAMPLE_W +: SAMPLE_W] = dac[i];
		end
		out_data[M_TDATA_W-1 -: 8] = digital_q;
	end

	assign out_valid  = valid_q;
	assign out_status = status_q;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for crc8_frame_receiver_unpacker: byte frames with good and bad CRC
// and header, aborted frames, idle timeouts and header/polynomial settings, checked
// against a cycle-free frame tracker. Depends on fcr_pkg and the rtl top level only.
`default_nettype none

module testbench;
	import fcr_pkg::*;

	localparam bit OP_BYTE    = 1'b0;
	localparam bit OP_TIMEOUT = 1'b1;

	typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_HDR, FRAME_BAD_BOTH} frame_kind_t;
	typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_EXTREMES} fill_t;

	typedef struct packed {
		fcr_status_t           status;
		logic [M_TDATA_W-1:0]  values;
	} readback_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	crc8_frame_receiver_unpacker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Frame tracker state
	logic [7:0]  cfg_header = HEADER_RESET;
	logic [7:0]  cfg_poly = POLY_RESET;
	int          rx_pos = 0;
	logic [7:0]  rx_crc = '0;
	logic [7:0]  rx_frame [0:STORE_DEPTH-1];
	logic [11:0] keep_adc [0:ADC_MAX-1] = '{default: '0};
	logic [11:0] keep_dac [0:DAC_MAX-1] = '{default: '0};
	logic [7:0]  keep_din = '0;

	readback_t   readback_q[$];
	int          mismatch_count = 0;
	int unsigned items_sent = 0;
	bit          idle_on = 1'b0;
	int          stall_left = 0;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// Two 12-bit samples per three bytes: high byte first, shared nibble in the middle
	function automatic logic [11:0] sample12(input int start, input int ch);
		int a;
		a = start + 3 * (ch / 2);
		if (ch % 2 == 0) begin
			return {rx_frame[a], rx_frame[a+1][7:4]};
		end
		return {rx_frame[a+1][3:0], rx_frame[a+2]};
	endfunction

	function automatic void track_item(input bit op, input logic [7:0] b);
		readback_t r;
		fcr_status_t st;
		if (op == OP_TIMEOUT) begin
			rx_pos = 0;
			rx_crc = '0;
			return;
		end
		if (rx_pos < STORE_DEPTH) begin
			rx_frame[rx_pos] = b;
			rx_crc = crc_step(rx_crc, b, cfg_poly);
			rx_pos++;
			return;
		end
		// CRC wins over header when both are wrong
		if (rx_crc != b) begin
			st = ST_CRC_ERR;
		end else if (rx_frame[HEADER_INDEX] != cfg_header) begin
			st = ST_HDR_ERR;
		end else begin
			st = ST_OK;
		end
		if (st == ST_OK) begin
			for (int i = 0; i < ADC_MAX; i++) keep_adc[i] = sample12(ADC_START, i);
			for (int i = 0; i < DAC_MAX; i++) keep_dac[i] = sample12(DAC_START, i);
			keep_din = rx_frame[DIGITAL_INDEX];
		end
		rx_pos = 0;
		rx_crc = '0;
		r.status = st;
		for (int i = 0; i < ADC_MAX; i++) r.values[i*SAMPLE_W +: SAMPLE_W] = keep_adc[i];
		for (int i = 0; i < DAC_MAX; i++) begin
			r.values[(ADC_MAX+i)*SAMPLE_W +: SAMPLE_W] = keep_dac[i];
		end
		r.values[M_TDATA_W-1 -: 8] = keep_din;
		readback_q.push_back(r);
	endfunction

	// Check each result against the oldest expectation; drive m_axis_tready
	always @(posedge clk) begin
		readback_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (readback_q.size() == 0) begin
				$display("%0t: unexpected result status %0d data %h", $time, m_axis_tuser,
					m_axis_tdata);
				mismatch_count++;
			end else begin
				want = readback_q.pop_front();
				if (m_axis_tuser != want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						m_axis_tuser);
					mismatch_count++;
				end
				for (int k = 0; k < ADC_MAX + DAC_MAX; k++) begin
					if (m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] !=
							want.values[k*SAMPLE_W +: SAMPLE_W]) begin
						$display("%0t: %s%0d expected %h got %h", $time,
							(k < ADC_MAX) ? "adc_ch" : "dac_ch",
							(k < ADC_MAX) ? k : k - ADC_MAX,
							want.values[k*SAMPLE_W +: SAMPLE_W],
							m_axis_tdata[k*SAMPLE_W +: SAMPLE_W]);
						mismatch_count++;
					end
				end
				if (m_axis_tdata[M_TDATA_W-1 -: 8] != want.values[M_TDATA_W-1 -: 8]) begin
					$display("%0t: digital_inputs expected %h got %h", $time,
						want.values[M_TDATA_W-1 -: 8], m_axis_tdata[M_TDATA_W-1 -: 8]);
					mismatch_count++;
				end
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Hold valid high across back-to-back items; drop it only for an idle burst
	task automatic send_item(input bit op, input logic [7:0] b);
		int gap;
		if (op == OP_BYTE || rx_pos != 0) items_sent++;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		track_item(op, b);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Send the first cut bytes of a frame; a short frame ends in a timeout
	task automatic send_frame(input frame_kind_t kind, input fill_t fill, input int cut);
		logic [7:0] frame_buf [0:FRAME_LENGTH-1];
		logic [7:0] crc;
		if (rx_pos != 0) send_item(OP_TIMEOUT, 8'($urandom));
		frame_buf[0] = (kind == FRAME_BAD_HDR || kind == FRAME_BAD_BOTH) ?
			cfg_header ^ 8'($urandom_range(1, 255)) : cfg_header;
		for (int i = 1; i < STORE_DEPTH; i++) begin
			case (fill)
				FILL_ZEROS: frame_buf[i] = 8'h00;
				FILL_ONES: frame_buf[i] = 8'hFF;
				FILL_EXTREMES: begin
					case ($urandom_range(0, 2))
						0: frame_buf[i] = 8'h00;
						1: frame_buf[i] = 8'hFF;
						default: frame_buf[i] = 8'($urandom);
					endcase
				end
				default: frame_buf[i] = 8'($urandom);
			endcase
		end
		crc = '0;
		for (int i = 0; i < STORE_DEPTH; i++) crc = crc_step(crc, frame_buf[i], cfg_poly);
		frame_buf[FRAME_LENGTH-1] = (kind == FRAME_BAD_CRC || kind == FRAME_BAD_BOTH) ?
			crc ^ 8'($urandom_range(1, 255)) : crc;
		for (int i = 0; i < cut; i++) send_item(OP_BYTE, frame_buf[i]);
		if (cut < FRAME_LENGTH) send_item(OP_TIMEOUT, 8'($urandom));
	endtask

	// Drop any partial frame and let the pipeline empty
	task automatic settle();
		if (rx_pos != 0) send_item(OP_TIMEOUT, 8'($urandom));
		s_axis_tvalid <= 1'b0;
		while (readback_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [7:0] header, input logic [7:0] poly);
		cfg_valid <= 1'b1;
		cfg_index <= REG_HEADER;
		cfg_data <= header;
		do @(posedge clk); while (!cfg_ready);
		cfg_header = header;
		cfg_index <= REG_POLY;
		cfg_data <= poly;
		do @(posedge clk); while (!cfg_ready);
		cfg_poly = poly;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_extreme_frames();
		idle_on = 1'b0;
		send_frame(FRAME_GOOD, FILL_ONES, FRAME_LENGTH);
		send_frame(FRAME_GOOD, FILL_ZEROS, FRAME_LENGTH);
		send_frame(FRAME_GOOD, FILL_RANDOM, FRAME_LENGTH);
	endtask

	// Bad frames must report the values of the last good one
	task automatic test_bad_frames();
		idle_on = 1'b1;
		send_frame(FRAME_GOOD, FILL_EXTREMES, FRAME_LENGTH);
		send_frame(FRAME_BAD_CRC, FILL_RANDOM, FRAME_LENGTH);
		send_frame(FRAME_BAD_HDR, FILL_RANDOM, FRAME_LENGTH);
		send_frame(FRAME_BAD_BOTH, FILL_RANDOM, FRAME_LENGTH);
	endtask

	task automatic test_timeouts();
		idle_on = 1'b1;
		send_item(OP_TIMEOUT, 8'hFF);
		send_frame(FRAME_GOOD, FILL_RANDOM, 7);
		send_frame(FRAME_GOOD, FILL_RANDOM, FRAME_LENGTH - 1);
		send_frame(FRAME_GOOD, FILL_RANDOM, FRAME_LENGTH);
	endtask

	task automatic test_register_sweep();
		logic [7:0] headers [0:3];
		logic [7:0] polys [0:3];
		headers = '{8'h00, 8'hFF, 8'($urandom), HEADER_RESET};
		polys = '{8'h00, 8'hFF, 8'($urandom), POLY_RESET};
		idle_on = 1'b1;
		for (int s = 0; s < 4; s++) begin
			settle();
			write_regs(headers[s], polys[s]);
			send_frame(FRAME_GOOD, FILL_RANDOM, FRAME_LENGTH);
			send_frame(FRAME_BAD_CRC, FILL_RANDOM, FRAME_LENGTH);
			send_frame(FRAME_BAD_HDR, FILL_EXTREMES, FRAME_LENGTH);
		end
	endtask

	// Mostly well-formed frames, some aborted ones and some raw noise
	task automatic test_random_traffic();
		int unsigned first;
		logic [7:0] header;
		logic [7:0] poly;
		int noise_len;
		first = items_sent;
		while (items_sent - first < 450) begin
			settle();
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: header = 8'h00;
					1: header = 8'hFF;
					default: header = 8'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: poly = 8'h00;
					1: poly = 8'hFF;
					default: poly = 8'($urandom);
				endcase
				write_regs(header, poly);
			end
			idle_on = ($urandom_range(0, 2) != 0);
			repeat (6) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send_frame(FRAME_GOOD, FILL_RANDOM, FRAME_LENGTH);
					4: send_frame(FRAME_BAD_CRC, FILL_RANDOM, FRAME_LENGTH);
					5: send_frame(FRAME_BAD_HDR, FILL_RANDOM, FRAME_LENGTH);
					6: send_frame(FRAME_BAD_BOTH, FILL_RANDOM, FRAME_LENGTH);
					7: send_frame(FRAME_GOOD, FILL_RANDOM, $urandom_range(1, FRAME_LENGTH - 1));
					8: begin
						noise_len = $urandom_range(1, 25);
						repeat (noise_len) begin
							send_item(($urandom_range(0, 3) == 0) ? OP_TIMEOUT : OP_BYTE,
								8'($urandom));
						end
					end
					default: send_frame(FRAME_GOOD, FILL_EXTREMES, FRAME_LENGTH);
				endcase
			end
		end
	endtask

	task automatic test_back_to_back();
		settle();
		idle_on = 1'b0;
		repeat (4) send_frame(FRAME_GOOD, FILL_RANDOM, FRAME_LENGTH);
		send_frame(FRAME_BAD_CRC, FILL_RANDOM, FRAME_LENGTH);
		send_frame(FRAME_GOOD, FILL_EXTREMES, FRAME_LENGTH);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_frames();
		test_bad_frames();
		test_timeouts();
		test_register_sweep();
		test_random_traffic();
		test_back_to_back();
		settle();
		if (mismatch_count == 0) begin
			$display("[crc8_frame_receiver_unpacker] OK");
		end else begin
			$display("[crc8_frame_receiver_unpacker] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[crc8_frame_receiver_unpacker] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
